// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk, held off during arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);
`else
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/core/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg
// shared types and constants of the page slot cache
// ----------------------------------------------------------------------------
package psc_pkg;

	localparam int SLOTS_DEF          = 4;
	localparam int CHUNK_BYTES_DEF    = 128;
	localparam int PAGE_BYTES_MAX_DEF = 8192;

	localparam int CFG_W    = 14;
	localparam int PB_W     = 17;
	localparam int OFF_W    = 21;
	localparam int PAGE_W   = 15;
	localparam int CIDX_W   = 10;
	localparam int CLEN_W   = 11;
	localparam int SEEN_W   = 11;
	localparam int SIDX_O_W = 4;
	localparam int WOFF_W   = 13;

	typedef enum logic [1:0] {
		MODE_LOOKUP = 2'd0,
		MODE_ALLOC  = 2'd1,
		MODE_CHUNK  = 2'd2,
		MODE_EVICT  = 2'd3
	} mode_t;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_MISS  = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	typedef struct packed {
		mode_t               mode;
		logic [PAGE_W-1:0]   page;
		logic [CIDX_W-1:0]   ctot;
		logic [WOFF_W-1:0]   woff;
		logic [CLEN_W-1:0]   wlen;
		logic                beyond;
		logic                unconf;
	} item_t;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic              ready;
		logic              loading;
		logic [SEEN_W-1:0] seen;
	} entry_t;

	typedef struct packed {
		logic [1:0]          status;
		logic                hit;
		logic [SIDX_O_W-1:0] slot_index;
		logic                clear_slot;
		logic [WOFF_W-1:0]   write_offset;
		logic [CLEN_W-1:0]   write_bytes;
		logic                page_complete;
		logic                ready_res;
		logic                loading;
	} res_t;

endpackage

// ===== rtl/core/psc_front.sv =====
// ----------------------------------------------------------------------------
// psc_front
// holds the page size register and classifies each incoming beat
// ----------------------------------------------------------------------------
module psc_front #(
	parameter int CHUNK_BYTES    = psc_pkg::CHUNK_BYTES_DEF,
	parameter int PAGE_BYTES_MAX = psc_pkg::PAGE_BYTES_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [psc_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic [1:0]                  mode,
	input  logic [psc_pkg::PAGE_W-1:0]  page_id,
	input  logic [psc_pkg::CIDX_W-1:0]  chunk_index,
	input  logic [psc_pkg::CIDX_W-1:0]  chunk_total,
	input  logic [psc_pkg::CLEN_W-1:0]  chunk_len,
	output psc_pkg::item_t              item
);

	logic [psc_pkg::PB_W-1:0]  page_bytes_q;
	logic [psc_pkg::PB_W-1:0]  cfg_ext;
	logic [psc_pkg::OFF_W-1:0] off;
	logic [psc_pkg::PB_W-1:0]  cap;
	logic                      beyond;

	assign cfg_ext = psc_pkg::PB_W'(cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_bytes_q <= '0;
		end else if (cfg_we) begin
			if (cfg_ext > psc_pkg::PB_W'(PAGE_BYTES_MAX)) begin
				page_bytes_q <= psc_pkg::PB_W'(PAGE_BYTES_MAX);
			end else begin
				page_bytes_q <= cfg_ext;
			end
		end
	end

	assign off    = psc_pkg::OFF_W'(chunk_index) * psc_pkg::OFF_W'(CHUNK_BYTES);
	assign beyond = off >= psc_pkg::OFF_W'(page_bytes_q);
	assign cap    = page_bytes_q - off[psc_pkg::PB_W-1:0];

	always_comb begin
		item        = '0;
		item.mode   = psc_pkg::mode_t'(mode);
		item.page   = page_id;
		item.ctot   = chunk_total;
		item.beyond = beyond;
		item.unconf = (page_bytes_q == '0);
		if (!beyond) begin
			item.woff = off[psc_pkg::WOFF_W-1:0];
			if (psc_pkg::PB_W'(chunk_len) < cap) begin
				item.wlen = chunk_len;
			end else begin
				item.wlen = cap[psc_pkg::CLEN_W-1:0];
			end
		end
	end

endmodule

// ===== rtl/core/psc_queue.sv =====
// ----------------------------------------------------------------------------
// psc_queue
// two-entry queue of classified beats between front and back
// ----------------------------------------------------------------------------
module psc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  psc_pkg::item_t din,
	input  logic           pop,
	output psc_pkg::item_t dout,
	output logic           full,
	output logic           empty
);

	psc_pkg::item_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ===== rtl/core/psc_back.sv =====
// ----------------------------------------------------------------------------
// psc_back
// scans the slots one per cycle, then carries out the beat and drives the result
// ----------------------------------------------------------------------------
module psc_back #(
	parameter int SLOTS = psc_pkg::SLOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           q_empty,
	input  psc_pkg::item_t q_head,
	output logic           q_pop,
	output logic           res_valid,
	output psc_pkg::res_t  res
);

	localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [2:0] {
		BK_IDLE = 3'b001,
		BK_SCAN = 3'b010,
		BK_EXEC = 3'b100
	} bk_state_t;

	bk_state_t                   state_q;
	logic [SLOTS-1:0]            slot_valid_q;
	psc_pkg::entry_t             slot_q [SLOTS];

	psc_pkg::item_t              cur_q;
	logic [SIDX_W-1:0]           idx_q;
	logic                        found_q;
	logic [SIDX_W-1:0]           found_idx_q;
	psc_pkg::entry_t             fnd_q;
	logic                        empty_q;
	logic [SIDX_W-1:0]           empty_idx_q;
	logic [psc_pkg::PAGE_W-1:0]  best_d_q;
	logic [SIDX_W-1:0]           best_idx_q;

	psc_pkg::res_t               res_q;
	logic                        res_valid_q;

	psc_pkg::entry_t             rd;
	logic [psc_pkg::PAGE_W-1:0]  page_gap;
	logic                        last;

	psc_pkg::res_t               nxt;
	logic                        wr_en;
	logic [SIDX_W-1:0]           wr_idx;
	psc_pkg::entry_t             wr_entry;
	logic                        set_v;
	logic                        clr_v;
	logic [psc_pkg::SEEN_W-1:0]  seen_n;

	assign rd       = slot_q[idx_q];
	assign page_gap = (rd.page > cur_q.page) ? (rd.page - cur_q.page) : (cur_q.page - rd.page);
	assign last     = (idx_q == SIDX_W'(SLOTS - 1));
	assign q_pop    = !q_empty && (state_q == BK_IDLE || state_q == BK_EXEC);

	assign seen_n = (fnd_q.seen == '1) ? fnd_q.seen : (fnd_q.seen + 1'b1);

	always_comb begin
		nxt      = '0;
		wr_en    = 1'b0;
		wr_idx   = found_idx_q;
		wr_entry = fnd_q;
		set_v    = 1'b0;
		clr_v    = 1'b0;
		nxt.hit  = found_q;
		if (found_q) begin
			nxt.slot_index = psc_pkg::SIDX_O_W'(found_idx_q);
		end
		unique case (cur_q.mode)
			psc_pkg::MODE_LOOKUP: begin
				if (!found_q) begin
					nxt.status = psc_pkg::STATUS_MISS;
				end else begin
					nxt.ready_res = fnd_q.ready;
					nxt.loading   = fnd_q.loading;
				end
			end
			psc_pkg::MODE_ALLOC: begin
				if (cur_q.unconf) begin
					nxt.status = psc_pkg::STATUS_MISS;
				end else begin
					priority if (found_q) begin
						wr_idx = found_idx_q;
					end else if (empty_q) begin
						wr_idx = empty_idx_q;
					end else begin
						wr_idx = best_idx_q;
					end
					wr_en            = 1'b1;
					set_v            = 1'b1;
					wr_entry.page    = cur_q.page;
					wr_entry.ready   = 1'b0;
					wr_entry.loading = 1'b1;
					wr_entry.seen    = '0;
					nxt.slot_index   = psc_pkg::SIDX_O_W'(wr_idx);
					nxt.clear_slot   = 1'b1;
					nxt.loading      = 1'b1;
				end
			end
			psc_pkg::MODE_CHUNK: begin
				if (!found_q) begin
					nxt.status = psc_pkg::STATUS_MISS;
				end else if (cur_q.beyond) begin
					nxt.status    = psc_pkg::STATUS_RANGE;
					nxt.ready_res = fnd_q.ready;
					nxt.loading   = fnd_q.loading;
				end else begin
					nxt.write_offset = cur_q.woff;
					nxt.write_bytes  = cur_q.wlen;
					wr_en            = 1'b1;
					wr_entry.seen    = seen_n;
					if (seen_n >= psc_pkg::SEEN_W'(cur_q.ctot)) begin
						wr_entry.ready    = 1'b1;
						wr_entry.loading  = 1'b0;
						nxt.page_complete = 1'b1;
					end
					nxt.ready_res = wr_entry.ready;
					nxt.loading   = wr_entry.loading;
				end
			end
			psc_pkg::MODE_EVICT: begin
				if (!found_q) begin
					nxt.status = psc_pkg::STATUS_MISS;
				end else begin
					clr_v          = 1'b1;
					nxt.clear_slot = 1'b1;
				end
			end
			default: begin
				nxt.status = psc_pkg::STATUS_MISS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			slot_valid_q <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			res_valid_q <= (state_q == BK_EXEC);
			unique case (state_q)
				BK_IDLE: begin
					if (q_pop) begin
						state_q <= BK_SCAN;
					end
				end
				BK_SCAN: begin
					if (last) begin
						state_q <= BK_EXEC;
					end
				end
				BK_EXEC: begin
					state_q <= q_pop ? BK_SCAN : BK_IDLE;
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
			if (cfg_we) begin
				slot_valid_q <= '0;
			end else if (state_q == BK_EXEC) begin
				if (set_v) begin
					slot_valid_q[wr_idx] <= 1'b1;
				end
				if (clr_v) begin
					slot_valid_q[found_idx_q] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_EXEC) begin
			res_q <= nxt;
			if (wr_en) begin
				slot_q[wr_idx] <= wr_entry;
			end
		end
		if (q_pop) begin
			cur_q       <= q_head;
			idx_q       <= '0;
			found_q     <= 1'b0;
			found_idx_q <= '0;
			empty_q     <= 1'b0;
			empty_idx_q <= '0;
			best_d_q    <= '0;
			best_idx_q  <= '0;
		end else if (state_q == BK_SCAN) begin
			idx_q <= idx_q + 1'b1;
			if (slot_valid_q[idx_q] && rd.page == cur_q.page && !found_q) begin
				found_q     <= 1'b1;
				found_idx_q <= idx_q;
				fnd_q       <= rd;
			end
			if (!slot_valid_q[idx_q] && !empty_q) begin
				empty_q     <= 1'b1;
				empty_idx_q <= idx_q;
			end
			if (page_gap > best_d_q) begin
				best_d_q   <= page_gap;
				best_idx_q <= idx_q;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/core/page_slot_cache_farthest_evict.sv =====
// ----------------------------------------------------------------------------
// page_slot_cache_farthest_evict
// a taken start passes the queue, the slot scan and exec; valid is registered
// the beat scans the slots one per cycle, then the exec state drives the result
// a two-beat queue lets start be taken while the scan runs; busy means it is full
// reset and every cfg_we write empty all slots; reset clears page_bytes to zero
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module page_slot_cache_farthest_evict #(
	parameter int SLOTS          = psc_pkg::SLOTS_DEF,
	parameter int CHUNK_BYTES    = psc_pkg::CHUNK_BYTES_DEF,
	parameter int PAGE_BYTES_MAX = psc_pkg::PAGE_BYTES_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [psc_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    mode,
	input  logic [psc_pkg::PAGE_W-1:0]    page_id,
	input  logic [psc_pkg::CIDX_W-1:0]    chunk_index,
	input  logic [psc_pkg::CIDX_W-1:0]    chunk_total,
	input  logic [psc_pkg::CLEN_W-1:0]    chunk_len,
	output logic                          valid,
	output logic [1:0]                    status,
	output logic                          hit,
	output logic [psc_pkg::SIDX_O_W-1:0]  slot_index,
	output logic                          clear_slot,
	output logic [psc_pkg::WOFF_W-1:0]    write_offset,
	output logic [psc_pkg::CLEN_W-1:0]    write_bytes,
	output logic                          page_complete,
	output logic                          ready_res,
	output logic                          loading
);

	psc_pkg::item_t in_item;
	psc_pkg::item_t q_head;
	psc_pkg::res_t  res;
	logic           q_full;
	logic           q_empty;
	logic           q_pop;
	logic           push;

	assign busy = q_full;
	assign push = start && !q_full;

	psc_front #(
		.CHUNK_BYTES   (CHUNK_BYTES),
		.PAGE_BYTES_MAX(PAGE_BYTES_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.mode       (mode),
		.page_id    (page_id),
		.chunk_index(chunk_index),
		.chunk_total(chunk_total),
		.chunk_len  (chunk_len),
		.item       (in_item)
	);

	psc_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (in_item),
		.pop   (q_pop),
		.dout  (q_head),
		.full  (q_full),
		.empty (q_empty)
	);

	psc_back #(
		.SLOTS(SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.res_valid(valid),
		.res      (res)
	);

	assign status        = res.status;
	assign hit           = res.hit;
	assign slot_index    = res.slot_index;
	assign clear_slot    = res.clear_slot;
	assign write_offset  = res.write_offset;
	assign write_bytes   = res.write_bytes;
	assign page_complete = res.page_complete;
	assign ready_res     = res.ready_res;
	assign loading       = res.loading;

	`ASSERT_NEVER(a_status_code, valid && status > psc_pkg::STATUS_RANGE, "undefined status code")
	`ASSERT_IMPLY(a_clear_ok, valid && clear_slot, status == psc_pkg::STATUS_OK && !ready_res, "clear on failed beat")
	`ASSERT_IMPLY(a_complete_flags, valid && page_complete, ready_res && !loading && hit, "complete page not ready")
	`ASSERT_NEVER(a_len_on_fail, valid && write_bytes != '0 && status != psc_pkg::STATUS_OK, "length on failed beat")

endmodule

// ===== sim/psc_result_checker.sv =====
// ----------------------------------------------------------------------------
// psc_result_checker
// watches the config, request and result channels of the page slot cache,
// keeps its own copy of the slot table and page size, predicts every result
// beat and compares it field by field with what the block delivers
// ----------------------------------------------------------------------------
module psc_result_checker
	import psc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic                start,
	input  logic                busy,
	input  logic [1:0]          mode,
	input  logic [PAGE_W-1:0]   page_id,
	input  logic [CIDX_W-1:0]   chunk_index,
	input  logic [CIDX_W-1:0]   chunk_total,
	input  logic [CLEN_W-1:0]   chunk_len,
	input  logic                valid,
	input  logic [1:0]          status,
	input  logic                hit,
	input  logic [SIDX_O_W-1:0] slot_index,
	input  logic                clear_slot,
	input  logic [WOFF_W-1:0]   write_offset,
	input  logic [CLEN_W-1:0]   write_bytes,
	input  logic                page_complete,
	input  logic                ready_res,
	input  logic                loading,
	output int                  fail_count,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT    = SLOTS_DEF;
	localparam int CHUNK    = CHUNK_BYTES_DEF;
	localparam int PB_MAX   = PAGE_BYTES_MAX_DEF;
	localparam int SEEN_CAP = 2047;

	bit   held[NSLOT];
	int   held_page[NSLOT];
	bit   held_ready[NSLOT];
	bit   held_loading[NSLOT];
	int   held_seen[NSLOT];
	int   page_bytes_m;
	res_t due_results[$];
	res_t oldest_due;

	function automatic void empty_slot(int i);
		held[i] = 1'b0;
		held_page[i] = 0;
		held_ready[i] = 1'b0;
		held_loading[i] = 1'b0;
		held_seen[i] = 0;
	endfunction

	function automatic void empty_all_slots();
		for (int i = 0; i < NSLOT; i++)
			empty_slot(i);
	endfunction

	function automatic int slot_of_page(int pg);
		int found;
		found = -1;
		for (int i = NSLOT - 1; i >= 0; i--)
			if (held[i] && held_page[i] == pg)
				found = i;
		return found;
	endfunction

	function automatic res_t predict_cache_op(logic [1:0] op, int pg, int cidx, int ctot,
			int clen);
		res_t r;
		int   s;
		int   pick;
		int   best;
		int   d;
		int   off;
		int   cap;
		r = '0;
		s = slot_of_page(pg);
		if (s >= 0) begin
			r.hit = 1'b1;
			r.slot_index = SIDX_O_W'(s);
		end
		case (mode_t'(op))
			MODE_LOOKUP: begin
				if (s < 0) begin
					r.status = STATUS_MISS;
				end else begin
					r.ready_res = held_ready[s];
					r.loading = held_loading[s];
				end
			end
			MODE_ALLOC: begin
				if (page_bytes_m == 0) begin
					r.status = STATUS_MISS;
				end else begin
					pick = s;
					for (int i = 0; i < NSLOT; i++)
						if (pick < 0 && !held[i])
							pick = i;
					if (pick < 0) begin
						best = 0;
						pick = 0;
						for (int i = 0; i < NSLOT; i++) begin
							d = (held_page[i] > pg) ? held_page[i] - pg : pg - held_page[i];
							if (d > best) begin
								best = d;
								pick = i;
							end
						end
					end
					empty_slot(pick);
					held[pick] = 1'b1;
					held_page[pick] = pg;
					held_loading[pick] = 1'b1;
					r.slot_index = SIDX_O_W'(pick);
					r.clear_slot = 1'b1;
					r.loading = 1'b1;
				end
			end
			MODE_CHUNK: begin
				if (s < 0) begin
					r.status = STATUS_MISS;
				end else begin
					off = cidx * CHUNK;
					if (off >= page_bytes_m) begin
						r.status = STATUS_RANGE;
					end else begin
						cap = page_bytes_m - off;
						r.write_offset = WOFF_W'(off);
						r.write_bytes = CLEN_W'((clen < cap) ? clen : cap);
						if (held_seen[s] < SEEN_CAP)
							held_seen[s]++;
						if (held_seen[s] >= ctot) begin
							held_ready[s] = 1'b1;
							held_loading[s] = 1'b0;
							r.page_complete = 1'b1;
						end
					end
					r.ready_res = held_ready[s];
					r.loading = held_loading[s];
				end
			end
			default: begin
				if (s < 0) begin
					r.status = STATUS_MISS;
				end else begin
					empty_slot(s);
					r.clear_slot = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_bytes_m = 0;
			empty_all_slots();
			due_results.delete();
			fail_count = 0;
		end else begin
			if (valid) begin
				if (due_results.size() == 0) begin
					$error("result beat with no request outstanding");
					fail_count++;
				end else begin
					oldest_due = due_results.pop_front();
					check_field("status", oldest_due.status, status);
					check_field("hit", oldest_due.hit, hit);
					check_field("slot_index", oldest_due.slot_index, slot_index);
					check_field("clear_slot", oldest_due.clear_slot, clear_slot);
					check_field("write_offset", oldest_due.write_offset, write_offset);
					check_field("write_bytes", oldest_due.write_bytes, write_bytes);
					check_field("page_complete", oldest_due.page_complete, page_complete);
					check_field("ready_res", oldest_due.ready_res, ready_res);
					check_field("loading", oldest_due.loading, loading);
				end
			end
			if (cfg_we) begin
				page_bytes_m = (int'(cfg_wdata) > PB_MAX) ? PB_MAX : int'(cfg_wdata);
				empty_all_slots();
			end
			if (start && !busy)
				due_results.push_back(predict_cache_op(mode, page_id, chunk_index,
					chunk_total, chunk_len));
		end
		pending = due_results.size();
	end

endmodule

// ===== sim/page_slot_cache_farthest_evict_tb.sv =====
// ----------------------------------------------------------------------------
// page_slot_cache_farthest_evict_tb
// drives lookup, alloc, chunk and evict requests into the page slot cache
// under several page sizes, directed corner cases first, then random traffic
// over small page pools and a long load that runs past a large chunk total
// ----------------------------------------------------------------------------
module page_slot_cache_farthest_evict_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import psc_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_W-1:0]    cfg_wdata;
	logic                start;
	logic                busy;
	logic [1:0]          mode;
	logic [PAGE_W-1:0]   page_id;
	logic [CIDX_W-1:0]   chunk_index;
	logic [CIDX_W-1:0]   chunk_total;
	logic [CLEN_W-1:0]   chunk_len;
	logic                valid;
	logic [1:0]          status;
	logic                hit;
	logic [SIDX_O_W-1:0] slot_index;
	logic                clear_slot;
	logic [WOFF_W-1:0]   write_offset;
	logic [CLEN_W-1:0]   write_bytes;
	logic                page_complete;
	logic                ready_res;
	logic                loading;
	int                  fail_count;
	int                  pending;

	int page_pool[6];
	int cfg_list[9];
	int gap_max;
	int cur_page_bytes;

	page_slot_cache_farthest_evict dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .mode(mode), .page_id(page_id),
		.chunk_index(chunk_index), .chunk_total(chunk_total), .chunk_len(chunk_len),
		.valid(valid), .status(status), .hit(hit), .slot_index(slot_index),
		.clear_slot(clear_slot), .write_offset(write_offset), .write_bytes(write_bytes),
		.page_complete(page_complete), .ready_res(ready_res), .loading(loading)
	);

	psc_result_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .mode(mode), .page_id(page_id),
		.chunk_index(chunk_index), .chunk_total(chunk_total), .chunk_len(chunk_len),
		.valid(valid), .status(status), .hit(hit), .slot_index(slot_index),
		.clear_slot(clear_slot), .write_offset(write_offset), .write_bytes(write_bytes),
		.page_complete(page_complete), .ready_res(ready_res), .loading(loading),
		.fail_count(fail_count), .pending(pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#5ms;
		$display("page_slot_cache_farthest_evict regression: fail");
		$finish;
	end

	// one request beat, entered and left on a falling edge
	task automatic send_op(logic [1:0] op, int pg, int cidx, int ctot, int clen);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		mode <= op;
		page_id <= PAGE_W'(pg);
		chunk_index <= CIDX_W'(cidx);
		chunk_total <= CIDX_W'(ctot);
		chunk_len <= CLEN_W'(clen);
		start <= 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_page_bytes(int v);
		wait_idle();
		cfg_wdata <= CFG_W'(v);
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_page_bytes = (v > PAGE_BYTES_MAX_DEF) ? PAGE_BYTES_MAX_DEF : v;
		@(negedge clk);
	endtask

	task automatic run_random(int n);
		int d;
		int c;
		int r;
		int pg;
		int nck;
		int cidx;
		int ctot;
		int clen;
		logic [1:0] op;
		d = $urandom_range(1, 2000);
		c = $urandom_range(d, 32767 - d);
		page_pool = '{c, c - d, c + d, 0, 32767, $urandom_range(0, 32767)};
		nck = (cur_page_bytes + CHUNK_BYTES_DEF - 1) / CHUNK_BYTES_DEF;
		for (int i = 0; i < n; i++) begin
			if (i % 64 == 0)
				gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
			if ($urandom_range(0, 149) == 0)
				wait_idle();
			r = $urandom_range(0, 99);
			if (r < 20)
				op = MODE_ALLOC;
			else if (r < 60)
				op = MODE_CHUNK;
			else if (r < 80)
				op = MODE_LOOKUP;
			else
				op = MODE_EVICT;
			if ($urandom_range(0, 9) == 0)
				pg = $urandom_range(0, 32767);
			else
				pg = page_pool[$urandom_range(0, 5)];
			cidx = ($urandom_range(0, 99) < 85) ? $urandom_range(0, nck) :
				$urandom_range(0, 1023);
			ctot = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 6) :
				$urandom_range(0, 1023);
			r = $urandom_range(0, 9);
			clen = (r < 5) ? CHUNK_BYTES_DEF : (r < 9) ? $urandom_range(0, 1024) : 1024;
			send_op(op, pg, cidx, ctot, clen);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		start = 1'b0;
		mode = MODE_LOOKUP;
		page_id = '0;
		chunk_index = '0;
		chunk_total = '0;
		chunk_len = '0;
		gap_max = 4;
		cur_page_bytes = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// unconfigured, empty table
		send_op(MODE_LOOKUP, 0, 0, 0, 0);
		send_op(MODE_ALLOC, 5, 0, 0, 0);
		send_op(MODE_CHUNK, 0, 0, 0, 128);
		send_op(MODE_EVICT, 0, 0, 0, 0);

		// short page with a clipped last chunk
		write_page_bytes(300);
		send_op(MODE_ALLOC, 100, 0, 0, 0);
		send_op(MODE_ALLOC, 100, 0, 0, 0);
		send_op(MODE_CHUNK, 100, 0, 2, 128);
		send_op(MODE_CHUNK, 100, 2, 2, 1024);
		send_op(MODE_CHUNK, 100, 3, 2, 128);
		send_op(MODE_CHUNK, 100, 1023, 1023, 1024);
		send_op(MODE_CHUNK, 100, 1, 2, 128);
		send_op(MODE_LOOKUP, 100, 0, 0, 0);
		send_op(MODE_ALLOC, 0, 0, 0, 0);
		send_op(MODE_ALLOC, 32767, 0, 0, 0);
		send_op(MODE_ALLOC, 200, 0, 0, 0);
		send_op(MODE_EVICT, 32767, 0, 0, 0);
		send_op(MODE_ALLOC, 300, 0, 0, 0);
		// equal distance to slots 0 and 3
		send_op(MODE_ALLOC, 150, 0, 0, 0);
		send_op(MODE_CHUNK, 150, 0, 0, 0);
		send_op(MODE_LOOKUP, 5, 0, 0, 0);
		send_op(MODE_EVICT, 150, 0, 0, 0);
		send_op(MODE_LOOKUP, 150, 0, 0, 0);

		cfg_list = '{16383, 1, 0, 8192, 100, 8191, 8193, $urandom_range(1, 8192),
			$urandom_range(0, 16383)};
		foreach (cfg_list[k]) begin
			write_page_bytes(cfg_list[k]);
			run_random((cfg_list[k] == 0) ? 40 : 100);
		end

		// one page loaded past a large chunk total
		write_page_bytes(8192);
		gap_max = 4;
		send_op(MODE_ALLOC, 7, 0, 0, 0);
		for (int i = 0; i < 1080; i++)
			send_op(MODE_CHUNK, 7, $urandom_range(0, 63), 1023, $urandom_range(0, 1024));
		send_op(MODE_LOOKUP, 7, 0, 0, 0);

		wait_idle();
		if (fail_count == 0)
			$display("page_slot_cache_farthest_evict regression: pass");
		else
			$display("page_slot_cache_farthest_evict regression: fail");
		$finish;
	end

endmodule
